// ===== hw/rtl/uapq_pkg.sv =====
// ----------------------------------------------------------------------------
// uapq_pkg
// Shared constants and command/status codes for the unsorted array priority
// queue.
// ----------------------------------------------------------------------------
package uapq_pkg;

    localparam int CAPACITY_DEFAULT      = 64;
    localparam int PRIORITY_BITS_DEFAULT = 16;
    localparam int DATA_BITS_DEFAULT     = 32;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_PEEK    = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic sample;
        logic first;
    } scan_ctl_t;

endpackage

// ===== hw/rtl/uapq_ram.sv =====
// ----------------------------------------------------------------------------
// uapq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uapq_ram #(
    parameter int WIDTH     = 48,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/uapq_max_scan.sv =====
// ----------------------------------------------------------------------------
// uapq_max_scan
// Running maximum over entries streamed one per cycle; the entry streamed
// first wins among equal priorities.
// ----------------------------------------------------------------------------
module uapq_max_scan #(
    parameter int PRIORITY_BITS = uapq_pkg::PRIORITY_BITS_DEFAULT,
    parameter int DATA_BITS     = uapq_pkg::DATA_BITS_DEFAULT,
    parameter int IDX_BITS      = $clog2(uapq_pkg::CAPACITY_DEFAULT)
) (
    input  logic                     clk,
    input  uapq_pkg::scan_ctl_t      ctl,
    input  logic [IDX_BITS-1:0]      entry_idx,
    input  logic [PRIORITY_BITS-1:0] entry_pri,
    input  logic [DATA_BITS-1:0]     entry_data,
    output logic [IDX_BITS-1:0]      best_idx,
    output logic [PRIORITY_BITS-1:0] best_pri,
    output logic [DATA_BITS-1:0]     best_data
);

    logic [IDX_BITS-1:0]      best_idx_reg;
    logic [PRIORITY_BITS-1:0] best_pri_reg;
    logic [DATA_BITS-1:0]     best_data_reg;
    logic                     take;

    assign take = ctl.sample && (ctl.first || (entry_pri > best_pri_reg));

    always_ff @(posedge clk) begin
        if (take) begin
            best_idx_reg  <= entry_idx;
            best_pri_reg  <= entry_pri;
            best_data_reg <= entry_data;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_pri  = best_pri_reg;
    assign best_data = best_data_reg;

endmodule

// ===== hw/rtl/unsorted_array_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_core
// Priority queue over an unsorted entry RAM with a linear maximum scan.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel carries a command in s_axis_tuser and,
// for an insert, a priority and payload in s_axis_tdata. Every request
// produces exactly one response on the m_axis channel with the maximum
// entry (extract and peek), a status code in m_axis_tuser and the entry
// count after the operation.
// An insert, a refused insert, a request on an empty queue and an unknown
// command go from acceptance straight to the response state, which loads
// the response register once it is free and returns to idle, where the
// next request can be accepted. Extract and peek read the stored entries
// one per cycle through the single RAM read port into one comparator, then
// pass through a wait state and a move state before the response state, so
// their time grows with the entry count.
// s_axis_tready is high only while no request is in progress.
// Reset empties the queue at once; the RAM needs no clearing pass.
// A stalled receiver holds the response in the output register; the next
// request is still accepted and processed, and its response waits until
// the output register is free.
// ----------------------------------------------------------------------------
module unsorted_array_priority_queue_core #(
    parameter int CAPACITY      = uapq_pkg::CAPACITY_DEFAULT,
    parameter int PRIORITY_BITS = uapq_pkg::PRIORITY_BITS_DEFAULT,
    parameter int DATA_BITS     = uapq_pkg::DATA_BITS_DEFAULT,
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1),
    localparam int S_TDATA_BITS = ((PRIORITY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((PRIORITY_BITS + DATA_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // item_priority, item_data
    input  logic [S_TDATA_BITS-1:0]          s_axis_tdata,
    // command
    input  logic [uapq_pkg::CMD_BITS-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_priority, out_data, entry_count
    output logic [M_TDATA_BITS-1:0]          m_axis_tdata,
    // status
    output logic [uapq_pkg::STATUS_BITS-1:0] m_axis_tuser
);

    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int ENTRY_BITS = PRIORITY_BITS + DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_MOVE,
        S_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [COUNT_BITS-1:0]           fill_reg, fill_next;
    logic [IDX_BITS-1:0]             scan_addr_reg, scan_addr_next;
    logic                            extract_reg, extract_next;
    logic                            rd_pending_reg, rd_pending_next;
    logic                            rd_first_reg, rd_first_next;
    logic [IDX_BITS-1:0]             rd_idx_reg, rd_idx_next;
    logic [PRIORITY_BITS-1:0]        res_pri_reg, res_pri_next;
    logic [DATA_BITS-1:0]            res_data_reg, res_data_next;
    logic [uapq_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [PRIORITY_BITS-1:0]        out_pri_reg, out_pri_next;
    logic [DATA_BITS-1:0]            out_data_reg, out_data_next;
    logic [COUNT_BITS-1:0]           out_count_reg, out_count_next;
    logic [uapq_pkg::STATUS_BITS-1:0] out_status_reg, out_status_next;

    logic                            accept;
    logic [uapq_pkg::CMD_BITS-1:0]   in_cmd;
    logic [PRIORITY_BITS-1:0]        in_pri;
    logic [DATA_BITS-1:0]            in_data;
    logic [IDX_BITS-1:0]             last_idx;
    logic                            is_full;

    logic                            wr_en;
    logic [IDX_BITS-1:0]             wr_addr;
    logic [ENTRY_BITS-1:0]           wr_data;
    logic                            rd_en;
    logic [ENTRY_BITS-1:0]           rd_data;

    uapq_pkg::scan_ctl_t             scan_ctl;
    logic [IDX_BITS-1:0]             best_idx;
    logic [PRIORITY_BITS-1:0]        best_pri;
    logic [DATA_BITS-1:0]            best_data;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser;
    assign in_pri        = s_axis_tdata[PRIORITY_BITS-1:0];
    assign in_data       = s_axis_tdata[ENTRY_BITS-1:PRIORITY_BITS];
    assign last_idx      = IDX_BITS'(fill_reg - COUNT_BITS'(1));
    assign is_full       = (fill_reg >= COUNT_BITS'(CAPACITY));

    assign rd_en = (state_reg == S_SCAN);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[IDX_BITS-1:0];
        wr_data = {in_data, in_pri};
        if (state_reg == S_MOVE) begin
            wr_en   = extract_reg;
            wr_addr = best_idx;
            wr_data = rd_data;
        end else if (accept && (in_cmd == uapq_pkg::CMD_INSERT) && !is_full) begin
            wr_en = 1'b1;
        end
    end

    uapq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    assign scan_ctl.sample = rd_pending_reg;
    assign scan_ctl.first  = rd_first_reg;

    uapq_max_scan #(
        .PRIORITY_BITS (PRIORITY_BITS),
        .DATA_BITS     (DATA_BITS),
        .IDX_BITS      (IDX_BITS)
    ) u_scan (
        .clk        (aclk),
        .ctl        (scan_ctl),
        .entry_idx  (rd_idx_reg),
        .entry_pri  (rd_data[PRIORITY_BITS-1:0]),
        .entry_data (rd_data[ENTRY_BITS-1:PRIORITY_BITS]),
        .best_idx   (best_idx),
        .best_pri   (best_pri),
        .best_data  (best_data)
    );

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        scan_addr_next  = scan_addr_reg;
        extract_next    = extract_reg;
        rd_pending_next = 1'b0;
        rd_first_next   = 1'b0;
        rd_idx_next     = scan_addr_reg;
        res_pri_next    = res_pri_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_pri_next    = out_pri_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_pri_next    = '0;
                    res_data_next   = '0;
                    res_status_next = uapq_pkg::ST_OK;
                    extract_next    = (in_cmd == uapq_pkg::CMD_EXTRACT);
                    state_next      = S_RESP;
                    if (in_cmd == uapq_pkg::CMD_INSERT) begin
                        if (is_full) begin
                            res_status_next = uapq_pkg::ST_FULL;
                        end else begin
                            fill_next = fill_reg + COUNT_BITS'(1);
                        end
                    end else if ((in_cmd == uapq_pkg::CMD_EXTRACT) ||
                                 (in_cmd == uapq_pkg::CMD_PEEK)) begin
                        if (fill_reg == '0) begin
                            res_status_next = uapq_pkg::ST_EMPTY;
                        end else begin
                            scan_addr_next = '0;
                            state_next     = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                rd_pending_next = 1'b1;
                rd_first_next   = (scan_addr_reg == '0);
                scan_addr_next  = scan_addr_reg + IDX_BITS'(1);
                if (scan_addr_reg == last_idx) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_MOVE;
            end
            S_MOVE: begin
                res_pri_next    = best_pri;
                res_data_next   = best_data;
                res_status_next = uapq_pkg::ST_OK;
                if (extract_reg) begin
                    fill_next = fill_reg - COUNT_BITS'(1);
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next    = 1'b1;
                    out_pri_next    = res_pri_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = fill_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            rd_pending_reg <= 1'b0;
            rd_first_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            rd_pending_reg <= rd_pending_next;
            rd_first_reg   <= rd_first_next;
            m_valid_reg    <= m_valid_next;
        end
        scan_addr_reg  <= scan_addr_next;
        extract_reg    <= extract_next;
        rd_idx_reg     <= rd_idx_next;
        res_pri_reg    <= res_pri_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_pri_reg    <= out_pri_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_BITS'({out_count_reg, out_data_reg, out_pri_reg});
    assign m_axis_tuser  = out_status_reg;

endmodule

// ===== verif/unsorted_array_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_core_tb
// Self-checking testbench for the unsorted array priority queue core.
// ----------------------------------------------------------------------------
// Requests are driven on the s_axis channel with random gaps, and responses
// are taken on the m_axis channel with random back-pressure. A behavioral
// queue predicts every response, and each one is compared with the oldest
// prediction. Directed requests cover the empty queue, field extremes,
// equal priorities and the unused command; random traffic then fills the
// queue to capacity and drains it several times, followed by mixed traffic.
// ----------------------------------------------------------------------------
module unsorted_array_priority_queue_core_tb;

    localparam int CAPACITY       = uapq_pkg::CAPACITY_DEFAULT;
    localparam int PRI_W          = uapq_pkg::PRIORITY_BITS_DEFAULT;
    localparam int DATA_W         = uapq_pkg::DATA_BITS_DEFAULT;
    localparam int CMD_W          = uapq_pkg::CMD_BITS;
    localparam int STATUS_W       = uapq_pkg::STATUS_BITS;
    localparam int COUNT_W        = $clog2(CAPACITY + 1);
    localparam int S_TDATA_W      = ((PRI_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((PRI_W + DATA_W + COUNT_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [PRI_W-1:0]    pri;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } queue_response_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // item_priority, item_data
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    // command
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // out_priority, out_data, entry_count
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // status
    logic [STATUS_W-1:0]   m_axis_tuser;

    logic [PRI_W-1:0]  model_pri [CAPACITY];
    logic [DATA_W-1:0] model_data [CAPACITY];
    int                model_fill;
    queue_response_t   expected_responses [$];
    int                fail_count;
    bit                idle_on;

    unsorted_array_priority_queue_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic queue_response_t predict_queue_response(
        input logic [CMD_W-1:0]  cmd,
        input logic [PRI_W-1:0]  pri,
        input logic [DATA_W-1:0] data
    );
        queue_response_t r;
        int              best;
        r = '0;
        r.status = uapq_pkg::ST_OK;
        case (cmd)
            uapq_pkg::CMD_INSERT: begin
                if (model_fill >= CAPACITY) begin
                    r.status = uapq_pkg::ST_FULL;
                end else begin
                    model_pri[model_fill]  = pri;
                    model_data[model_fill] = data;
                    model_fill++;
                end
            end
            uapq_pkg::CMD_EXTRACT, uapq_pkg::CMD_PEEK: begin
                if (model_fill == 0) begin
                    r.status = uapq_pkg::ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < model_fill; i++) begin
                        if (model_pri[i] > model_pri[best]) best = i;
                    end
                    r.pri  = model_pri[best];
                    r.data = model_data[best];
                    if (cmd == uapq_pkg::CMD_EXTRACT) begin
                        model_pri[best]  = model_pri[model_fill-1];
                        model_data[best] = model_data[model_fill-1];
                        model_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.count = model_fill[COUNT_W-1:0];
        return r;
    endfunction

    // Most gaps are short; a few are longer, but none lasts a full-queue scan.
    function automatic int random_gap();
        int pick;
        if (!idle_on) return 0;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Narrow priority ranges give many ties between stored entries.
    function automatic logic [PRI_W-1:0] random_priority();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return PRI_W'($urandom_range(7));
        if (pick < 48) return '0;
        if (pick < 56) return '1;
        return PRI_W'($urandom);
    endfunction

    task automatic send_request(
        input logic [CMD_W-1:0]  cmd,
        input logic [PRI_W-1:0]  pri,
        input logic [DATA_W-1:0] data
    );
        int              gap;
        queue_response_t resp;
        gap = random_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({data, pri});
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        resp = predict_queue_response(cmd, pri, data);
        expected_responses = {expected_responses, resp};
    endtask

    task automatic send_random_request(input int insert_pct, input int extract_pct,
                                       input int peek_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            send_request(uapq_pkg::CMD_INSERT, random_priority(), $urandom);
        else if (pick < insert_pct + extract_pct)
            send_request(uapq_pkg::CMD_EXTRACT, random_priority(), $urandom);
        else if (pick < insert_pct + extract_pct + peek_pct)
            send_request(uapq_pkg::CMD_PEEK, random_priority(), $urandom);
        else
            send_request(CMD_NONE, random_priority(), $urandom);
    endtask

    task automatic test_empty_queue();
        send_request(uapq_pkg::CMD_EXTRACT, '1, '1);
        send_request(uapq_pkg::CMD_PEEK, '1, '1);
        send_request(CMD_NONE, '1, '1);
    endtask

    task automatic test_field_extremes();
        send_request(uapq_pkg::CMD_INSERT, '0, '0);
        send_request(uapq_pkg::CMD_INSERT, '1, '1);
        send_request(uapq_pkg::CMD_INSERT, 16'h8000, 32'h5555_5555);
        send_request(uapq_pkg::CMD_INSERT, 16'h0001, 32'hAAAA_AAAA);
        send_request(uapq_pkg::CMD_PEEK, '0, '0);
        repeat (4) send_request(uapq_pkg::CMD_EXTRACT, '0, '0);
    endtask

    task automatic test_equal_priorities();
        send_request(uapq_pkg::CMD_INSERT, 16'h1234, 32'h0000_000A);
        send_request(uapq_pkg::CMD_INSERT, 16'h0100, 32'h0000_000B);
        send_request(uapq_pkg::CMD_INSERT, 16'h1234, 32'h0000_000C);
        send_request(uapq_pkg::CMD_INSERT, 16'h1234, 32'h0000_000D);
        send_request(uapq_pkg::CMD_PEEK, '0, '0);
        repeat (4) send_request(uapq_pkg::CMD_EXTRACT, '0, '0);
    endtask

    task automatic test_unknown_command();
        send_request(uapq_pkg::CMD_INSERT, 16'h00FF, 32'h1234_5678);
        send_request(CMD_NONE, '1, '1);
        send_request(uapq_pkg::CMD_PEEK, '0, '0);
        send_request(uapq_pkg::CMD_EXTRACT, '0, '0);
    endtask

    // Each round fills the queue past capacity and then drains it past empty.
    task automatic test_capacity_cycles(input int rounds);
        int extra;
        for (int round = 0; round < rounds; round++) begin
            idle_on = (round != 1);
            extra = $urandom_range(1, 4);
            while (model_fill < CAPACITY || extra > 0) begin
                if (model_fill == CAPACITY) extra--;
                send_random_request(85, 4, 8);
            end
            extra = $urandom_range(1, 3);
            while (model_fill > 0 || extra > 0) begin
                if (model_fill == 0) extra--;
                send_random_request(5, 80, 12);
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_mixed_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            idle_on = !(i >= count / 3 && i < count / 2);
            send_random_request(45, 35, 15);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        int ready_run;
        int stall_run;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            ready_run = $urandom_range(1, 8);
            stall_run = random_gap();
            m_axis_tready <= 1'b1;
            repeat (ready_run) @(posedge aclk);
            if (stall_run > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_run) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        queue_response_t got;
        queue_response_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.pri    = m_axis_tdata[PRI_W-1:0];
            got.data   = m_axis_tdata[PRI_W +: DATA_W];
            got.count  = m_axis_tdata[PRI_W + DATA_W +: COUNT_W];
            got.status = m_axis_tuser;
            if (expected_responses.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected response: pri=%h data=%h status=%0d count=%0d",
                             got.pri, got.data, got.status, got.count);
            end else begin
                want = expected_responses.pop_front();
                if (got.pri !== want.pri || got.data !== want.data ||
                    got.status !== want.status || got.count !== want.count) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected pri=%h data=%h status=%0d count=%0d",
                                 want.pri, want.data, want.status, want.count);
                        $display("          got      pri=%h data=%h status=%0d count=%0d",
                                 got.pri, got.data, got.status, got.count);
                    end
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        fail_count    = 0;
        model_fill    = 0;
        idle_on       = 1'b1;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= uapq_pkg::CMD_INSERT;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_field_extremes();
        test_equal_priorities();
        test_unknown_command();
        test_capacity_cycles(5);
        test_mixed_traffic(680);

        s_axis_tvalid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/uapq_pkg.sv
hw/rtl/uapq_ram.sv
hw/rtl/uapq_max_scan.sv
hw/rtl/unsorted_array_priority_queue_core.sv
verif/unsorted_array_priority_queue_core_tb.sv
